[design/wes_pkg.sv]
package wes_pkg;

  localparam int HEIGHT_BITS   = 16;
  localparam int COEF_BITS     = 16;
  localparam int COEF_FRAC     = 13;
  localparam int OPND_BITS     = HEIGHT_BITS + 2;
  localparam int ACC_BITS      = COEF_BITS + OPND_BITS + 2;
  localparam int ROW_BITS      = 12;
  localparam int ROWS_CFG_BITS = 13;
  localparam int COLS_CFG_BITS = 11;
  localparam int ROW_LIMIT     = 4096;
  localparam int MIN_DIM       = 3;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;
  localparam int FIFO_DEPTH    = 8;
  localparam int FIFO_AW       = $clog2(FIFO_DEPTH);

  typedef logic signed [HEIGHT_BITS-1:0] height_t;
  typedef logic signed [COEF_BITS-1:0]   coef_t;
  typedef logic signed [OPND_BITS-1:0]   operand_t;
  typedef logic signed [ACC_BITS-1:0]    acc_t;

  localparam height_t H_MAX = {1'b0, {(HEIGHT_BITS-1){1'b1}}};
  localparam height_t H_MIN = {1'b1, {(HEIGHT_BITS-1){1'b0}}};
  localparam acc_t ROUND_HALF = acc_t'(1) <<< (COEF_FRAC - 1);

  localparam coef_t COEF_PREV_RST     = -16'sd8192;
  localparam coef_t COEF_CENTER_RST   = 16'sd12288;
  localparam coef_t COEF_NEIGHBOR_RST = 16'sd2048;
  localparam logic [ROWS_CFG_BITS-1:0] NUM_ROWS_RST = 13'd200;
  localparam logic [COLS_CFG_BITS-1:0] NUM_COLS_RST = 11'd200;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_COEF_PREV     = 3'd0,
    REG_COEF_CENTER   = 3'd1,
    REG_COEF_NEIGHBOR = 3'd2,
    REG_NUM_ROWS      = 3'd3,
    REG_NUM_COLS      = 3'd4
  } cfg_reg_t;

  // Token passed along the multiply-accumulate chain.
  typedef struct packed {
    logic     valid;
    logic     interior;
    logic     emit_up;
    logic     emit_self;
    logic     done;
    height_t  prev_c;
    height_t  self_h;
    operand_t op0;
    operand_t op1;
    operand_t op2;
    acc_t     acc;
  } mac_tok_t;

  // Results caused by one input word: one or two output words.
  typedef struct packed {
    logic    two;
    height_t h0;
    logic    d0;
    height_t h1;
    logic    d1;
  } entry_t;

endpackage

[design/wes_if.sv]
interface wes_in_if import wes_pkg::*; ();
  logic    valid;
  logic    ready;
  height_t prev_height;
  height_t curr_height;

  modport source (output valid, prev_height, curr_height, input ready);
  modport sink (input valid, prev_height, curr_height, output ready);
endinterface

interface wes_out_if import wes_pkg::*; ();
  logic    valid;
  logic    ready;
  height_t new_height;
  logic    last_in_run;
  logic    grid_done;

  modport source (output valid, new_height, last_in_run, grid_done, input ready);
  modport sink (input valid, new_height, last_in_run, grid_done, output ready);
endinterface

interface wes_cfg_if import wes_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[design/wave_equation_stencil_step_top.sv]
// Path: a word accepted on the cell channel passes the read stage, three MAC cells
//   and the result queue before its first result word shows on the result channel.
// Throughput: one grid cell per cycle while the result queue has room; on the last
//   row each cell yields two result words, so the single result port paces that row.
// Reset: row and column position return to zero and the registers to their defaults;
//   the line stores are not cleared and hold valid data once a row has streamed in.
module wave_equation_stencil_step_top import wes_pkg::*; #(
  parameter int MAX_COLS = 1024
) (
  input logic       clk,
  input logic       rst,
  wes_in_if.sink    cells,
  wes_out_if.source results,
  wes_cfg_if.sink   cfg
);

  localparam int COL_AW   = $clog2(MAX_COLS);
  localparam int CW       = ($clog2(MAX_COLS + 1) > COLS_CFG_BITS) ?
                            $clog2(MAX_COLS + 1) : COLS_CFG_BITS;
  localparam int RES_BITS = $clog2(FIFO_DEPTH + 1);

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes are registered as they arrive; ready is always high.
  // ---------------------------------------------------------------------------
  coef_t                    coef_prev;
  coef_t                    coef_center;
  coef_t                    coef_neighbor;
  logic [ROWS_CFG_BITS-1:0] num_rows;
  logic [COLS_CFG_BITS-1:0] num_cols;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_prev     <= COEF_PREV_RST;
      coef_center   <= COEF_CENTER_RST;
      coef_neighbor <= COEF_NEIGHBOR_RST;
      num_rows      <= NUM_ROWS_RST;
      num_cols      <= NUM_COLS_RST;
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_COEF_PREV:     coef_prev     <= coef_t'(cfg.data);
        REG_COEF_CENTER:   coef_center   <= coef_t'(cfg.data);
        REG_COEF_NEIGHBOR: coef_neighbor <= coef_t'(cfg.data);
        REG_NUM_ROWS:      num_rows      <= cfg.data[ROWS_CFG_BITS-1:0];
        REG_NUM_COLS:      num_cols      <= cfg.data[COLS_CFG_BITS-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Grid position. Clamp the sizes to their legal range, and clamp the stored
  // position to the current size so a shrink between words lands on the last
  // row or column.
  // ---------------------------------------------------------------------------
  logic [ROW_BITS-1:0]      row_index;
  logic [COL_AW-1:0]        col_index;
  logic [CW-1:0]            cols_wide;
  logic [CW-1:0]            cols_eff;
  logic [ROWS_CFG_BITS-1:0] rows_eff;
  logic [COL_AW-1:0]        col_last;
  logic [ROW_BITS-1:0]      row_last;
  logic [COL_AW-1:0]        col_cur;
  logic [ROW_BITS-1:0]      row_cur;
  logic [COL_AW-1:0]        col_right;
  logic [COL_AW-1:0]        col_index_next;
  logic [ROW_BITS-1:0]      row_index_next;
  logic                     emit_up;
  logic                     emit_self;
  logic                     interior;
  logic                     at_last_col;
  logic                     has_res;
  logic                     accept;

  always_comb begin
    cols_wide = CW'(num_cols);
    if (cols_wide < CW'(MIN_DIM)) begin
      cols_eff = CW'(MIN_DIM);
    end else if (cols_wide > CW'(MAX_COLS)) begin
      cols_eff = CW'(MAX_COLS);
    end else begin
      cols_eff = cols_wide;
    end
    col_last = COL_AW'(cols_eff - CW'(1));

    if (num_rows < ROWS_CFG_BITS'(MIN_DIM)) begin
      rows_eff = ROWS_CFG_BITS'(MIN_DIM);
    end else if (num_rows > ROWS_CFG_BITS'(ROW_LIMIT)) begin
      rows_eff = ROWS_CFG_BITS'(ROW_LIMIT);
    end else begin
      rows_eff = num_rows;
    end
    row_last = ROW_BITS'(rows_eff - ROWS_CFG_BITS'(1));

    col_cur = (col_index > col_last) ? col_last : col_index;
    row_cur = (row_index > row_last) ? row_last : row_index;

    at_last_col = (col_cur == col_last);
    // The right neighbor is only needed off the last column; hold the address
    // in range there.
    col_right   = at_last_col ? col_cur : col_cur + COL_AW'(1);
    emit_up     = (row_cur != '0);
    emit_self   = (row_cur == row_last);
    interior    = (row_cur >= ROW_BITS'(2)) && (col_cur != '0) && !at_last_col;
    has_res     = emit_up | emit_self;

    if (at_last_col) begin
      col_index_next = '0;
      row_index_next = (row_cur == row_last) ? '0 : row_cur + ROW_BITS'(1);
    end else begin
      col_index_next = col_cur + COL_AW'(1);
      row_index_next = row_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_index <= '0;
      col_index <= '0;
    end else if (accept) begin
      row_index <= row_index_next;
      col_index <= col_index_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Read stage. The line stores are read at the accept edge; the word's own
  // heights are written back in the following cycle, when the column is already free.
  // The current-height store is kept twice so center and right read at once.
  // The history store packs {height two rows up, previous height one row up}.
  // ---------------------------------------------------------------------------
  logic                       v1;
  logic [COL_AW-1:0]          c1;
  height_t                    p1;
  height_t                    q1;
  logic                       int1;
  logic                       up1;
  logic                       self1;
  logic                       done1;
  height_t                    left_h;
  logic [HEIGHT_BITS-1:0]     center_rd;
  logic [HEIGHT_BITS-1:0]     right_rd;
  logic [2*HEIGHT_BITS-1:0]   hist_rd;

  wes_line_store #(
    .WIDTH (HEIGHT_BITS),
    .DEPTH (MAX_COLS)
  ) u_above_center (
    .clk   (clk),
    .we    (v1),
    .waddr (c1),
    .wdata (q1),
    .re    (accept),
    .raddr (col_cur),
    .rdata (center_rd)
  );

  wes_line_store #(
    .WIDTH (HEIGHT_BITS),
    .DEPTH (MAX_COLS)
  ) u_above_right (
    .clk   (clk),
    .we    (v1),
    .waddr (c1),
    .wdata (q1),
    .re    (accept),
    .raddr (col_right),
    .rdata (right_rd)
  );

  wes_line_store #(
    .WIDTH (2 * HEIGHT_BITS),
    .DEPTH (MAX_COLS)
  ) u_history (
    .clk   (clk),
    .we    (v1),
    .waddr (c1),
    .wdata ({center_rd, p1}),
    .re    (accept),
    .raddr (col_cur),
    .rdata (hist_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= accept;
    end
  end

  // The left neighbor is the center read by the word before, which sat one
  // column to the left in the same row whenever the cell is interior.
  always_ff @(posedge clk) begin
    if (accept) begin
      c1     <= col_cur;
      p1     <= cells.prev_height;
      q1     <= cells.curr_height;
      int1   <= interior;
      up1    <= emit_up;
      self1  <= emit_self;
      done1  <= at_last_col;
      left_h <= height_t'(center_rd);
    end
  end

  // Build the token for the MAC chain.
  height_t  up_h;
  height_t  prev_c;
  height_t  center_h;
  height_t  right_h;
  operand_t nsum;
  mac_tok_t tok0;

  always_comb begin
    up_h     = hist_rd[2*HEIGHT_BITS-1:HEIGHT_BITS];
    prev_c   = hist_rd[HEIGHT_BITS-1:0];
    center_h = center_rd;
    right_h  = right_rd;
    nsum     = operand_t'(up_h) + operand_t'(q1) + operand_t'(left_h) + operand_t'(right_h);

    tok0.valid     = v1;
    tok0.interior  = int1;
    tok0.emit_up   = up1;
    tok0.emit_self = self1;
    tok0.done      = done1;
    tok0.prev_c    = prev_c;
    tok0.self_h    = p1;
    tok0.op0       = operand_t'(prev_c);
    tok0.op1       = operand_t'(center_h);
    tok0.op2       = nsum;
    tok0.acc       = '0;
  end

  // ---------------------------------------------------------------------------
  // MAC chain: each cell adds one weighted term and passes the token on.
  // ---------------------------------------------------------------------------
  mac_tok_t tok1;
  mac_tok_t tok2;
  mac_tok_t tok3;

  wes_mac_cell u_cell_prev (
    .clk     (clk),
    .rst     (rst),
    .tok_in  (tok0),
    .coef    (coef_prev),
    .x       (tok0.op0),
    .tok_out (tok1)
  );

  wes_mac_cell u_cell_center (
    .clk     (clk),
    .rst     (rst),
    .tok_in  (tok1),
    .coef    (coef_center),
    .x       (tok1.op1),
    .tok_out (tok2)
  );

  wes_mac_cell u_cell_neighbor (
    .clk     (clk),
    .rst     (rst),
    .tok_in  (tok2),
    .coef    (coef_neighbor),
    .x       (tok2.op2),
    .tok_out (tok3)
  );

  // ---------------------------------------------------------------------------
  // Round half up out of the Q3.13 coefficient scale, saturate, and form the result entry.
  // ---------------------------------------------------------------------------
  acc_t    rounded;
  acc_t    scaled;
  height_t stencil_h;
  entry_t  entry;
  logic    push;

  always_comb begin
    rounded = tok3.acc + ROUND_HALF;
    scaled  = rounded >>> COEF_FRAC;
    if (scaled > acc_t'(H_MAX)) begin
      stencil_h = H_MAX;
    end else if (scaled < acc_t'(H_MIN)) begin
      stencil_h = H_MIN;
    end else begin
      stencil_h = height_t'(scaled);
    end

    entry.two = tok3.emit_up & tok3.emit_self;
    if (tok3.emit_up) begin
      // Boundary cells keep their previous height.
      entry.h0 = tok3.interior ? stencil_h : tok3.prev_c;
      entry.d0 = 1'b0;
    end else begin
      entry.h0 = tok3.self_h;
      entry.d0 = tok3.done;
    end
    entry.h1 = tok3.self_h;
    entry.d1 = tok3.done;

    push = tok3.valid & (tok3.emit_up | tok3.emit_self);
  end

  // ---------------------------------------------------------------------------
  // Result queue. A slot is reserved at accept for every word that yields
  // results, so the pipeline never stalls and the queue never overflows.
  // ---------------------------------------------------------------------------
  entry_t              fifo_mem [FIFO_DEPTH];
  logic [FIFO_AW:0]    wr_ptr;
  logic [FIFO_AW:0]    rd_ptr;
  logic                sub;
  logic [RES_BITS-1:0] reserved;
  entry_t              head;
  logic                pop;
  logic                pop_last;

  assign cells.ready = (reserved < RES_BITS'(FIFO_DEPTH));
  assign accept      = cells.valid & cells.ready;

  always_comb begin
    head                = fifo_mem[rd_ptr[FIFO_AW-1:0]];
    results.valid       = (wr_ptr != rd_ptr);
    results.new_height  = sub ? head.h1 : head.h0;
    results.grid_done   = sub ? head.d1 : head.d0;
    results.last_in_run = sub | !head.two;
    pop                 = results.valid & results.ready;
    pop_last            = pop & (sub | !head.two);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr[FIFO_AW-1:0]] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      sub      <= 1'b0;
      reserved <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + (FIFO_AW + 1)'(1);
      end
      // Advance to the next entry after its last word; otherwise step to the
      // second word of a pair.
      if (pop_last) begin
        rd_ptr <= rd_ptr + (FIFO_AW + 1)'(1);
        sub    <= 1'b0;
      end else if (pop) begin
        sub    <= 1'b1;
      end
      reserved <= reserved + RES_BITS'(accept & has_res) - RES_BITS'(pop_last);
    end
  end

endmodule

[design/wes_line_store.sv]
module wes_line_store #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/wes_mac_cell.sv]
module wes_mac_cell import wes_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  mac_tok_t tok_in,
  input  coef_t    coef,
  input  operand_t x,
  output mac_tok_t tok_out
);

  acc_t     coef_w;
  acc_t     x_w;
  mac_tok_t tok_next;

  always_comb begin
    coef_w       = acc_t'(coef);
    x_w          = acc_t'(x);
    tok_next     = tok_in;
    tok_next.acc = tok_in.acc + coef_w * x_w;
  end

  // Add this cell's term and hand the token on.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

endmodule

[dv/wave_equation_stencil_step_top_tb.sv]
`timescale 1ns / 100ps

module wave_equation_stencil_step_top_tb import wes_pkg::*; ();

  localparam int          MAX_COLS      = 1024;
  localparam int unsigned SETTLE_CYCLES = 16;      // well past the pipeline latency
  localparam int unsigned LONG_HOLD     = 400;
  localparam int unsigned PHASE_CELLS   = 150;
  localparam int unsigned CYCLE_LIMIT   = 500000;

  localparam coef_t COEF_TOP    = 16'sh7fff;
  localparam coef_t COEF_BOTTOM = 16'sh8000;

  typedef enum int unsigned { FILL_ANY, FILL_SMALL, FILL_EDGE } fill_t;
  typedef enum int unsigned { COEF_ANY, COEF_NEAR_RESET, COEF_EXTREME } coef_style_t;
  typedef enum int unsigned { PRESS_NONE, PRESS_HOLD_RESULTS, PRESS_PAUSE_CELLS } press_t;

  typedef struct packed {
    height_t prv;
    height_t cur;
  } cell_word_t;

  typedef struct packed {
    height_t height;
    logic    last_in_run;
    logic    grid_done;
  } height_result_t;

  logic clk = 1'b0;
  logic rst;

  wes_in_if  cells_if ();
  wes_out_if results_if ();
  wes_cfg_if cfg_if ();

  wave_equation_stencil_step_top #(.MAX_COLS(MAX_COLS)) dut (
    .clk     (clk),
    .rst     (rst),
    .cells   (cells_if),
    .results (results_if),
    .cfg     (cfg_if)
  );

  // 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Stencil predictor: own copy of the registers, the three line stores and
  // the raster position.
  // ---------------------------------------------------------------------------
  coef_t                     k_prev   = COEF_PREV_RST;
  coef_t                     k_center = COEF_CENTER_RST;
  coef_t                     k_nbr    = COEF_NEIGHBOR_RST;
  logic [ROWS_CFG_BITS-1:0]  rows_reg = NUM_ROWS_RST;
  logic [COLS_CFG_BITS-1:0]  cols_reg = NUM_COLS_RST;

  height_t above_curr [MAX_COLS];
  height_t two_above  [MAX_COLS];
  height_t above_prev [MAX_COLS];
  int unsigned row_pos = 0;
  int unsigned col_pos = 0;

  height_result_t pending_heights [$];   // result words still to arrive, oldest first
  cell_word_t     cells_to_send   [$];   // words the driver has yet to offer

  int unsigned cells_queued   = 0;
  int unsigned cells_accepted = 0;
  int unsigned results_seen   = 0;
  int unsigned reg_writes     = 0;
  int unsigned grids_queued   = 0;
  int unsigned fail_count     = 0;
  int unsigned cycle_count    = 0;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  logic        send_pause     = 1'b0;
  logic        res_hold       = 1'b0;
  logic        cell_taken     = 1'b0;
  event        hold_results_ev;

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    return (v < MIN_DIM) ? MIN_DIM : ((v > hi) ? hi : v);
  endfunction

  function automatic int unsigned cells_per_grid();
    return clamp_dim(rows_reg, ROW_LIMIT) * clamp_dim(cols_reg, MAX_COLS);
  endfunction

  // Work out the result words one accepted cell causes and advance the stores.
  task automatic next_heights_for_cell(height_t prv, height_t cur);
    int unsigned    ncols, nrows, r, c, n, i;
    longint         nsum, acc;
    height_result_t emit [2];
    ncols = clamp_dim(cols_reg, MAX_COLS);
    nrows = clamp_dim(rows_reg, ROW_LIMIT);
    // a position past a shrunk size counts as the last row or column
    r = (row_pos > nrows - 1) ? nrows - 1 : row_pos;
    c = (col_pos > ncols - 1) ? ncols - 1 : col_pos;
    n = 0;
    if (r >= 1) begin
      emit[n].last_in_run = 1'b0;
      emit[n].grid_done   = 1'b0;
      if (r >= 2 && c >= 1 && c <= ncols - 2) begin
        // left neighbor already moved into the two-above store
        nsum = longint'(two_above[c]) + longint'(cur) + longint'(two_above[c-1])
             + longint'(above_curr[c+1]);
        acc  = longint'(k_prev) * longint'(above_prev[c])
             + longint'(k_center) * longint'(above_curr[c])
             + longint'(k_nbr) * nsum + (longint'(1) <<< (COEF_FRAC - 1));
        acc  = acc >>> COEF_FRAC;
        if (acc > longint'(H_MAX)) emit[n].height = H_MAX;
        else if (acc < longint'(H_MIN)) emit[n].height = H_MIN;
        else emit[n].height = height_t'(acc);
      end else begin
        // boundary cell holds its previous height
        emit[n].height = above_prev[c];
      end
      n++;
    end
    if (r == nrows - 1) begin
      emit[n] = '{prv, 1'b0, (c == ncols - 1)};
      n++;
    end
    if (n > 0) emit[n-1].last_in_run = 1'b1;
    for (i = 0; i < n; i++) pending_heights.push_back(emit[i]);
    two_above[c]  = above_curr[c];
    above_curr[c] = cur;
    above_prev[c] = prv;
    if (c >= ncols - 1) begin
      col_pos = 0;
      row_pos = (r >= nrows - 1) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
      row_pos = r;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Cell driver: change at the falling edge, hold a word until it is taken.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : drive_cells
    cell_word_t w;
    if (rst) begin
      cells_if.valid <= 1'b0;
    end else if (!cells_if.valid || cell_taken) begin
      if (cells_to_send.size() != 0 && !send_pause &&
          $urandom_range(99) >= send_idle_pct) begin
        w = cells_to_send.pop_front();
        cells_if.valid       <= 1'b1;
        cells_if.prev_height <= w.prv;
        cells_if.curr_height <= w.cur;
      end else begin
        cells_if.valid <= 1'b0;
      end
    end
  end

  // Result back-pressure: random stalls, or a long hold while one is armed.
  always @(negedge clk) begin
    if (rst || res_hold) begin
      results_if.ready <= 1'b0;
    end else begin
      results_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Long result hold-off, counted here so the sender keeps streaming meanwhile.
  initial begin : result_hold_off
    int unsigned k;
    forever begin
      @(hold_results_ev);
      res_hold <= 1'b1;
      for (k = 0; k < LONG_HOLD; k++) @(negedge clk);
      res_hold <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on each accepted cell word, check each result word.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch
    height_result_t e;
    if (!rst) begin
      if (cells_if.valid && cells_if.ready) begin
        next_heights_for_cell(cells_if.prev_height, cells_if.curr_height);
        cells_accepted++;
      end
      if (results_if.valid && results_if.ready) begin
        results_seen++;
        if (pending_heights.size() == 0) begin
          $display("%0t: unexpected result word: expected none, got height %0d last %0b done %0b",
                   $time, results_if.new_height, results_if.last_in_run,
                   results_if.grid_done);
          fail_count++;
        end else begin
          e = pending_heights.pop_front();
          if (results_if.new_height !== e.height) begin
            $display("%0t: new_height expected %0d, got %0d",
                     $time, e.height, results_if.new_height);
            fail_count++;
          end
          if (results_if.last_in_run !== e.last_in_run) begin
            $display("%0t: last_in_run expected %0b, got %0b",
                     $time, e.last_in_run, results_if.last_in_run);
            fail_count++;
          end
          if (results_if.grid_done !== e.grid_done) begin
            $display("%0t: grid_done expected %0b, got %0b",
                     $time, e.grid_done, results_if.grid_done);
            fail_count++;
          end
        end
      end
    end
    cell_taken <= cells_if.valid && cells_if.ready;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d result words outstanding", $time, pending_heights.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic add_cell(height_t p, height_t q);
    cells_to_send.push_back('{p, q});
    cells_queued++;
  endtask

  function automatic height_t rand_height(fill_t f);
    case (f)
      FILL_SMALL: return height_t'(int'($urandom_range(4095)) - 2048);
      FILL_EDGE:  return $urandom_range(1) ? height_t'(H_MAX - height_t'($urandom_range(3)))
                                           : height_t'(H_MIN + height_t'($urandom_range(3)));
      default:    return height_t'($urandom);
    endcase
  endfunction

  function automatic coef_t rand_coef(coef_style_t style, coef_t nominal);
    case (style)
      COEF_NEAR_RESET: return nominal + coef_t'(int'($urandom_range(2048)) - 1024);
      COEF_EXTREME: begin
        case ($urandom_range(2))
          0:       return COEF_TOP;
          1:       return COEF_BOTTOM;
          default: return '0;
        endcase
      end
      default: return coef_t'($urandom);
    endcase
  endfunction

  // Queue one whole grid at the current size, starting from position zero.
  task automatic queue_grid(fill_t f);
    int unsigned k, total;
    total = cells_per_grid();
    for (k = 0; k < total; k++) add_cell(rand_height(f), rand_height(f));
    grids_queued++;
  endtask

  // Write one register; call only while the block is idle.
  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] val);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      REG_COEF_PREV:     k_prev   = val;
      REG_COEF_CENTER:   k_center = val;
      REG_COEF_NEIGHBOR: k_nbr    = val;
      REG_NUM_ROWS:      rows_reg = val[ROWS_CFG_BITS-1:0];
      REG_NUM_COLS:      cols_reg = val[COLS_CFG_BITS-1:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Wait until every word is taken and every result is in, then let words that
  // cause no result clear the pipeline.
  task automatic settle();
    while (cells_accepted != cells_queued || pending_heights.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_traffic(int unsigned send_pct, int unsigned recv_pct);
    @(negedge clk);
    send_idle_pct  <= send_pct;
    recv_stall_pct <= recv_pct;
  endtask

  task automatic randomize_regs();
    coef_style_t style;
    int unsigned rows, cols;
    style = coef_style_t'($urandom_range(3) % 3);
    rows  = ($urandom_range(9) == 0) ? $urandom_range(2) : 3 + $urandom_range(5);
    case ($urandom_range(9))
      0:       cols = $urandom_range(2);
      1:       cols = 13 + $urandom_range(35);
      default: cols = 3 + $urandom_range(9);
    endcase
    write_reg(REG_COEF_PREV,     rand_coef(style, COEF_PREV_RST));
    write_reg(REG_COEF_CENTER,   rand_coef(style, COEF_CENTER_RST));
    write_reg(REG_COEF_NEIGHBOR, rand_coef(style, COEF_NEIGHBOR_RST));
    write_reg(REG_NUM_ROWS,      CFG_DATA_BITS'(rows));
    write_reg(REG_NUM_COLS,      CFG_DATA_BITS'(cols));
  endtask

  // Whole grids with random content under fresh settings until the goal is met.
  task automatic random_run(int unsigned goal, press_t press);
    int unsigned done_here, grids, g, base;
    done_here = 0;
    while (done_here < goal) begin
      settle();
      randomize_regs();
      base  = cells_queued;
      grids = 1 + $urandom_range(3);
      for (g = 0; g < grids || (press != PRESS_NONE && cells_queued - base < 60); g++) begin
        queue_grid(fill_t'($urandom_range(2)));
      end
      done_here += cells_queued - base;
      if (press == PRESS_HOLD_RESULTS) begin
        // hold results while the sender floods; the block must stall its input
        -> hold_results_ev;
      end else if (press == PRESS_PAUSE_CELLS) begin
        // drop the sender halfway until every pending result is back
        while (cells_accepted < base + (cells_queued - base) / 2) @(negedge clk);
        send_pause <= 1'b1;
        do @(negedge clk); while (pending_heights.size() != 0 || cells_if.valid);
        send_pause <= 1'b0;
      end
      press = PRESS_NONE;
    end
    settle();
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned k;
    rst                  = 1'b1;
    cfg_if.valid         = 1'b0;
    cfg_if.index         = '0;
    cfg_if.data          = '0;
    for (k = 0; k < MAX_COLS; k++) begin
      above_curr[k] = '0;
      two_above[k]  = '0;
      above_prev[k] = '0;
    end
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Directed: top coefficients and top heights saturate high; sizes below
    // the minimum clamp to three.
    write_reg(REG_COEF_PREV,     COEF_TOP);
    write_reg(REG_COEF_CENTER,   COEF_TOP);
    write_reg(REG_COEF_NEIGHBOR, COEF_TOP);
    write_reg(REG_NUM_ROWS,      16'd0);
    write_reg(REG_NUM_COLS,      16'd0);
    for (k = 0; k < 9; k++) add_cell(H_MAX, H_MAX);
    settle();

    // Bottom heights saturate low.
    write_reg(REG_NUM_ROWS, 16'd2);
    write_reg(REG_NUM_COLS, 16'd1);
    for (k = 0; k < 9; k++) add_cell(H_MIN, H_MIN);
    settle();

    // Round half up: +0.5 rounds to one, -0.5 rounds to zero.
    write_reg(REG_COEF_PREV,     COEF_BOTTOM);
    write_reg(REG_COEF_CENTER,   16'sd4096);
    write_reg(REG_COEF_NEIGHBOR, 16'sd0);
    write_reg(REG_NUM_ROWS,      16'd3);
    write_reg(REG_NUM_COLS,      16'd4);
    for (k = 0; k < 4; k++) add_cell(rand_height(FILL_ANY), rand_height(FILL_ANY));
    add_cell(rand_height(FILL_ANY), rand_height(FILL_ANY));
    add_cell(16'sd0, 16'sd1);
    add_cell(16'sd0, -16'sd1);
    add_cell(rand_height(FILL_ANY), rand_height(FILL_ANY));
    for (k = 0; k < 4; k++) add_cell(rand_height(FILL_ANY), rand_height(FILL_ANY));
    settle();

    // Widest grid: column count clamps to the store depth. Stream one full
    // row and part of the next, then shrink the size mid-grid so the held
    // position counts as the last column, and later as the last row.
    write_reg(REG_COEF_PREV,     rand_coef(COEF_NEAR_RESET, COEF_PREV_RST));
    write_reg(REG_COEF_CENTER,   rand_coef(COEF_NEAR_RESET, COEF_CENTER_RST));
    write_reg(REG_COEF_NEIGHBOR, rand_coef(COEF_NEAR_RESET, COEF_NEIGHBOR_RST));
    write_reg(REG_NUM_ROWS,      16'd8191);
    write_reg(REG_NUM_COLS,      16'd2047);
    for (k = 0; k < MAX_COLS + 6; k++) add_cell(rand_height(FILL_SMALL), rand_height(FILL_SMALL));
    settle();
    write_reg(REG_NUM_COLS, 16'd3);
    for (k = 0; k < 7; k++) add_cell(rand_height(FILL_SMALL), rand_height(FILL_SMALL));
    settle();
    write_reg(REG_NUM_ROWS, 16'd3);
    for (k = 0; k < 3; k++) add_cell(rand_height(FILL_SMALL), rand_height(FILL_SMALL));
    settle();

    // Random grids under four traffic mixes.
    random_run(PHASE_CELLS, PRESS_HOLD_RESULTS);
    set_traffic(78, 0);
    random_run(PHASE_CELLS, PRESS_PAUSE_CELLS);
    set_traffic(0, 78);
    random_run(PHASE_CELLS, PRESS_NONE);
    set_traffic(17, 17);
    random_run(PHASE_CELLS, PRESS_NONE);
    settle();

    $display("Streamed %0d cells in %0d grids and checked %0d result words",
             cells_accepted, grids_queued + 4, results_seen);
    $display("with %0d register writes over idle, stalled and held traffic", reg_writes);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[files.f]
design/wes_pkg.sv
design/wes_if.sv
design/wes_line_store.sv
design/wes_mac_cell.sv
design/wave_equation_stencil_step_top.sv
dv/wave_equation_stencil_step_top_tb.sv
